@@ hw/rtl/sdr_pkg.sv @@
// shared constants and controller/datapath handshake types for the duplicate remover
`default_nettype none

package sdr_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int VALUE_W       = 32;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic finish;
   } sdr_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } sdr_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/sdr_ctrl.sv @@
// controller state machine: accept, scan the store, write back the result
`default_nettype none

module sdr_ctrl
   import sdr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire sdr_status_type status,
   output sdr_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in      = state_ff;
      ready_in      = ready_ff;
      cmd.capture   = req_valid && ready_ff;
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.finish    = (state_ff == ST_FINISH) && status.out_free;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               state_in = ST_SCAN;
               ready_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (state_ff == ST_IDLE))
      else $error("ready outside idle");

   a_capture_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_SCAN))
      else $error("transfer did not start scan");

   a_finish_reopens: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> ready_ff)
      else $error("input not reopened after result load");

endmodule

`default_nettype wire

@@ hw/rtl/sdr_datapath.sv @@
// datapath: value store, sequential match scan, entry count and result register
`default_nettype none

module sdr_datapath
   import sdr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sdr_cmd_type               cmd,
   output sdr_status_type                 status,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_last,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_value_out,
   output logic                           rsp_keep,
   output logic                           rsp_last_out,
   output logic                           rsp_overflow
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   logic signed [VALUE_W-1:0] mem [DEPTH];

   logic signed [VALUE_W-1:0] value_ff;
   logic                      last_ff;
   logic                      hit_ff, hit_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_keep_ff, rsp_last_ff, rsp_ovf_ff;
   logic                      rd_en;
   logic                      wr_en;
   logic                      full;

   assign full  = (count_ff == FULL);
   assign rd_en = cmd.scan_step && (idx_ff != count_ff);
   assign wr_en = cmd.finish && !hit_ff && !full;

   always_comb begin
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      rd_valid_in  = rd_en;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.capture) begin
         idx_in      = '0;
         hit_in      = 1'b0;
         rd_valid_in = 1'b0;
      end else begin
         if (rd_en) begin
            idx_in = idx_ff + CW'(1);
         end
         if (rd_valid_ff && (rd_data_ff == value_ff)) begin
            hit_in = 1'b1;
         end
      end
      if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.finish && last_ff) begin
         count_in = '0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= req_value;
         last_ff  <= req_last;
      end
      if (cmd.finish) begin
         rsp_value_ff <= value_ff;
         rsp_keep_ff  <= !hit_ff;
         rsp_last_ff  <= last_ff;
         rsp_ovf_ff   <= !hit_ff && full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         rd_valid_ff  <= rd_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.scan_done = (idx_ff == count_ff) && !rd_valid_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_keep      = rsp_keep_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count past depth");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (idx_ff <= count_ff))
      else $error("scan index past entry count");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && last_ff) |=> (count_ff == '0))
      else $error("count not cleared at end of sequence");

endmodule

`default_nettype wire

@@ hw/rtl/stream_duplicate_remover_core.sv @@
// top level: keeps first occurrence of each value within a sequence while the store has room
// flow: a transfer is captured, the store is scanned for a match, then the result is
// loaded once the result output is free, so a stalled result output delays it
// the store is scanned one entry per cycle through its read port; a new item is taken
// the cycle after the previous result is loaded, while that result waits
// reset: entry count and control cleared; store contents are not cleared
`default_nettype none

module stream_duplicate_remover_core
   import sdr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_last,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_value_out,
   output logic                           rsp_keep,
   output logic                           rsp_last_out,
   output logic                           rsp_overflow
);

   sdr_cmd_type    cmd;
   sdr_status_type status;

   sdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdr_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_keep      (rsp_keep),
      .rsp_last_out  (rsp_last_out),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire
